>>> rtl/mcre_pkg.sv
// Package for the multichannel curved ramp envelope unit.
// Holds opcodes, result kinds, slot settings and result record types.
// No dependencies.
`timescale 1ns / 1ps

package mcre_pkg;

  // Default number of slots
  localparam int unsigned SlotsDef = 16;

  // Field widths fixed by the stream format
  localparam int unsigned ValW   = 14;
  localparam int unsigned MsW    = 16;
  localparam int unsigned CurveW = 12;
  localparam int unsigned TickW  = 8;
  localparam int unsigned ElW    = 18;
  localparam int unsigned MaskW  = 16;

  localparam logic [ElW-1:0]  ElapsedMax = 18'h3FFFF;
  localparam logic [ValW-1:0] ValueMax   = 14'h3FFF;

  // Input opcodes
  localparam logic [1:0] OpStart   = 2'd0;
  localparam logic [1:0] OpStop    = 2'd1;
  localparam logic [1:0] OpStopAll = 2'd2;
  localparam logic [1:0] OpTick    = 2'd3;

  // Result kinds
  localparam logic [1:0] KindValue = 2'd0;
  localparam logic [1:0] KindStart = 2'd1;
  localparam logic [1:0] KindStop  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] RegTickMs    = 2'd0;
  localparam logic [1:0] RegMinChange = 2'd1;

  // Stored settings of one slot
  typedef struct packed {
    logic [ValW-1:0]   start;
    logic [ValW-1:0]   target;
    logic [MsW-1:0]    delay;
    logic [MsW-1:0]    attack;
    logic [MsW-1:0]    ret;
    logic [CurveW-1:0] curve;
  } slot_set_t;

  // One result record, without its last flag
  typedef struct packed {
    logic [1:0]       kind;
    logic [3:0]       slot;
    logic [ValW-1:0]  value;
    logic [MaskW-1:0] mask;
  } res_t;

endpackage

>>> rtl/multichannel_curved_ramp_envelope_unit.sv
// Multichannel curved ramp envelope unit: top level with sequencer, shared
// divider and shared multiplier. Depends on mcre_pkg.
//
//  Channel  | Direction | tdata (low bit up)                              | tuser  | tlast
//  s_axis   | in        | slot, start, target, delay, attack, return, curve | opcode | -
//  m_axis   | out       | slot_res, value, active_mask                    | kind   | last
//  cfg      | in        | index 0 tick_ms, index 1 min_change             | -      | -
//
// Start, stop and a no-op pass from decode to flush; stop all walks every slot first.
// A tick walks the slots one a cycle, save that each active slot in a ramp phase
// holds the walk while the 16-step shared divider (one quotient bit a cycle) and the
// shared multiplier work out its value, with a second division for a logarithmic curve.
// Reset returns the sequencer to idle, clears the active flags and the result
// valids, and restores the register defaults.
// A stalled result output holds the sequencer whenever a further result is due.
`timescale 1ns / 1ps

module multichannel_curved_ramp_envelope_unit #(
  parameter int unsigned SLOTS = mcre_pkg::SlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // slot[3:0], start_value[17:4], target_value[31:18], delay_ms[47:32],
  // attack_ms[63:48], return_ms[79:64], curve[91:80], zero[95:92]
  input  logic [95:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // slot_res[3:0], value[17:4], active_mask[33:18], zero[39:34]
  output logic [39:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i
);
  import mcre_pkg::*;

  localparam int unsigned SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Sequencer states
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDec   = 4'd1;
  localparam logic [3:0] StAll   = 4'd2;
  localparam logic [3:0] StScan  = 4'd3;
  localparam logic [3:0] StPh1   = 4'd4;
  localparam logic [3:0] StPh2   = 4'd5;
  localparam logic [3:0] StDivP  = 4'd6;
  localparam logic [3:0] StCset  = 4'd7;
  localparam logic [3:0] StDivE  = 4'd8;
  localparam logic [3:0] StMul1  = 4'd9;
  localparam logic [3:0] StExp   = 4'd10;
  localparam logic [3:0] StMul2  = 4'd11;
  localparam logic [3:0] StBlend = 4'd12;
  localparam logic [3:0] StFin1  = 4'd13;
  localparam logic [3:0] StFin2  = 4'd14;
  localparam logic [3:0] StFlush = 4'd15;

  logic [3:0]        state_q, state_d;
  logic [SlotW-1:0]  cur_q, cur_d;
  logic [SLOTS-1:0]  active_q, active_d;
  logic [TickW-1:0]  tick_q;
  logic [ValW-1:0]   minc_q;

  // Captured input request
  logic [1:0]  in_op_q;
  slot_set_t   in_set_q;
  logic [3:0]  in_slot_q;

  // Per-slot stores, written at start and during ticks
  logic [ElW-1:0] el_q [SLOTS];
  slot_set_t      set_q [SLOTS];

  // Working registers
  logic [ElW-1:0]       t_q, t_d;
  logic [MsW-1:0]       p_q, p_d;
  logic signed [12:0]   cv_q, cv_d;
  logic [19:0]          e_q, e_d;
  logic [16:0]          c_q, c_d;
  logic signed [42:0]   prod_q, prod_d;
  logic [ValW-1:0]      from_q, from_d, to_q, to_d;

  // Shared restoring divider
  logic [15:0] rem_q, rem_d, den_q, den_d, quo_q, quo_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [16:0] div_sh;
  logic        div_ge;
  logic [15:0] div_rem_n, div_quo_n;

  // Result path
  res_t        pend_q, out_q;
  logic        pend_valid_q, out_valid_q, out_last_q;
  logic        emit, flush_move, out_free, hold;
  logic [1:0]  e_kind;
  logic [3:0]  e_slot;
  logic [ValW-1:0]  e_value;
  logic [MaskW-1:0] mask_w;

  // Store write controls
  logic             el_we, set_we;
  logic [SlotW-1:0] el_wa;
  logic [ElW-1:0]   el_wd;

  // Datapath helpers
  slot_set_t        st;
  logic [SlotW-1:0] in_idx;
  logic             in_slot_ok, cur_last;
  logic [3:0]       cur_slot4;
  logic [ValW-1:0]  diff_abs;
  logic [ElW:0]     tsum;
  logic [ElW-1:0]   tsat;
  logic [4:0]       k;
  logic [31:0]      p_sh;
  logic [20:0]      n_w;
  logic signed [21:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [42:0] mul_p;
  logic [23:0]      m_w;
  logic [16:0]      c_res;
  logic signed [13:0] dneg;
  logic [13:0]      e_base;
  logic signed [14:0] diff_s;
  logic signed [42:0] q_w;
  logic signed [43:0] v_w;
  logic [ValW-1:0]  v_sat;

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;

  assign st         = set_q[cur_q];
  assign in_idx     = SlotW'(in_slot_q);
  assign in_slot_ok = ({3'b0, in_slot_q} < 7'(SLOTS));
  assign cur_last   = (cur_q == SlotW'(SLOTS - 1));
  assign cur_slot4  = 4'(cur_q);
  assign diff_abs   = (in_set_q.start > in_set_q.target) ?
                      in_set_q.start - in_set_q.target : in_set_q.target - in_set_q.start;

  // Saturating elapsed time
  assign tsum = {1'b0, el_q[cur_q]} + 19'(tick_q);
  assign tsat = tsum[ElW] ? ElapsedMax : tsum[ElW-1:0];

  // Divider step: one quotient bit a cycle
  assign div_sh    = {rem_q, 1'b0};
  assign div_ge    = (div_sh >= {1'b0, den_q});
  assign div_rem_n = div_ge ? 16'(div_sh - {1'b0, den_q}) : div_sh[15:0];
  assign div_quo_n = {quo_q[14:0], div_ge};

  // Mitchell log2: leading one of the progress and the mantissa bits
  always_comb begin
    k = 5'd0;
    for (int b = 0; b < 16; b++) begin
      if (p_q[b]) k = 5'(b);
    end
  end
  assign p_sh = {16'b0, p_q} << (5'd16 - k);
  assign n_w  = {5'(5'd16 - k), 16'b0} - {5'b0, p_sh[15:0]};

  // Shared multiplier: exponent times log, then span times curved progress
  assign diff_s = $signed({1'b0, to_q}) - $signed({1'b0, from_q});
  assign mul_a  = (state_q == StMul1) ? $signed({1'b0, n_w}) : 22'(diff_s);
  assign mul_b  = (state_q == StMul1) ? $signed({1'b0, e_q}) : $signed({4'b0, c_q});
  assign mul_p  = mul_a * mul_b;

  // Mitchell exp2 of the scaled log
  assign m_w = prod_q[39:16];
  always_comb begin
    if (m_w[15:0] == 16'd0) begin
      c_res = (m_w[23:16] > 8'd17) ? 17'd0 : (17'h10000 >> m_w[23:16]);
    end else begin
      c_res = (m_w[23:16] >= 8'd18) ? 17'd0 :
              17'((18'h20000 - {2'b0, m_w[15:0]}) >> (m_w[23:16] + 8'd1));
    end
  end

  // Exponent for the exponential branch
  assign dneg   = 14'sd1024 - 14'(cv_q);
  assign e_base = 14'(14'sd1024 + 14'sd3 * dneg);

  // Blend with truncation toward zero and saturation
  assign q_w   = (prod_q >>> 16) +
                 $signed({42'b0, (prod_q < 0) && (prod_q[15:0] != 16'd0)});
  assign v_w   = $signed({30'b0, from_q}) + 44'(q_w);
  assign v_sat = (v_w < 0) ? '0 : (v_w > 44'sd16383) ? ValueMax : v_w[ValW-1:0];

  assign out_free = !out_valid_q || m_axis_tready;
  assign hold     = pend_valid_q && !out_free;

  // Active mask as seen after the reported event
  for (genvar g = 0; g < MaskW; g++) begin : g_mask
    if (g < SLOTS) begin : g_on
      assign mask_w[g] = active_d[g];
    end else begin : g_off
      assign mask_w[g] = 1'b0;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q; cur_d = cur_q; active_d = active_q;
    t_d = t_q; p_d = p_q; cv_d = cv_q; e_d = e_q; c_d = c_q; prod_d = prod_q;
    from_d = from_q; to_d = to_q;
    rem_d = rem_q; den_d = den_q; quo_d = quo_q; cnt_d = cnt_q;
    emit = 1'b0; e_kind = KindValue; e_slot = cur_slot4; e_value = '0;
    flush_move = 1'b0;
    el_we = 1'b0; el_wa = cur_q; el_wd = tsat; set_we = 1'b0;
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) state_d = StDec;
      end
      StDec: begin
        state_d = StFlush;
        e_slot  = in_slot_q;
        case (in_op_q)
          OpStart: begin
            if (in_slot_ok && !active_q[in_idx] && diff_abs >= minc_q) begin
              emit = 1'b1;
              if (in_set_q.attack == '0) begin
                e_value = in_set_q.target;
              end else begin
                set_we = 1'b1;
                el_we  = 1'b1;
                el_wa  = in_idx;
                el_wd  = '0;
                active_d[in_idx] = 1'b1;
                e_kind = KindStart;
              end
            end
          end
          OpStop: begin
            if (in_slot_ok && active_q[in_idx]) begin
              active_d[in_idx] = 1'b0;
              emit   = 1'b1;
              e_kind = KindStop;
            end
          end
          OpStopAll: begin
            cur_d   = '0;
            state_d = StAll;
          end
          default: begin
            cur_d   = '0;
            state_d = StScan;
          end
        endcase
      end
      StAll: begin
        if (!hold) begin
          if (active_q[cur_q]) begin
            active_d[cur_q] = 1'b0;
            emit   = 1'b1;
            e_kind = KindStop;
          end
          if (cur_last) state_d = StFlush;
          else cur_d = cur_q + 1'b1;
        end
      end
      StScan: begin
        if (active_q[cur_q]) begin
          el_we = 1'b1;
          if (tsat < {2'b0, st.delay}) begin
            if (cur_last) state_d = StFlush;
            else cur_d = cur_q + 1'b1;
          end else begin
            t_d     = tsat - {2'b0, st.delay};
            state_d = StPh1;
          end
        end else if (cur_last) begin
          state_d = StFlush;
        end else begin
          cur_d = cur_q + 1'b1;
        end
      end
      StPh1: begin
        if (t_q < {2'b0, st.attack}) begin
          rem_d = t_q[15:0]; den_d = st.attack; cnt_d = '0;
          cv_d  = $signed({1'b0, st.curve});
          from_d = st.start; to_d = st.target;
          state_d = StDivP;
        end else begin
          t_d     = t_q - {2'b0, st.attack};
          state_d = StPh2;
        end
      end
      StPh2: begin
        if (st.ret != '0 && t_q < {2'b0, st.ret}) begin
          rem_d = t_q[15:0]; den_d = st.ret; cnt_d = '0;
          cv_d  = 13'sd2048 - $signed({1'b0, st.curve});
          from_d = st.target; to_d = st.start;
          state_d = StDivP;
        end else begin
          state_d = StFin1;
        end
      end
      StDivP: begin
        rem_d = div_rem_n; quo_d = div_quo_n; cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          p_d     = div_quo_n;
          state_d = StCset;
        end
      end
      StCset: begin
        if (cv_q == 13'sd1024) begin
          c_d = {1'b0, p_q}; state_d = StMul2;
        end else if (p_q == '0) begin
          c_d = '0; state_d = StMul2;
        end else if (cv_q < 13'sd1024) begin
          e_d = {e_base, 6'b0}; state_d = StMul1;
        end else begin
          rem_d = 16'd1024; cnt_d = '0;
          den_d = 16'(16'd3 * 16'(cv_q) - 16'd2048);
          state_d = StDivE;
        end
      end
      StDivE: begin
        rem_d = div_rem_n; quo_d = div_quo_n; cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          e_d     = {4'b0, div_quo_n};
          state_d = StMul1;
        end
      end
      StMul1: begin
        prod_d = mul_p; state_d = StExp;
      end
      StExp: begin
        c_d = c_res; state_d = StMul2;
      end
      StMul2: begin
        prod_d = mul_p; state_d = StBlend;
      end
      StBlend: begin
        if (!hold) begin
          emit = 1'b1; e_value = v_sat;
          if (cur_last) state_d = StFlush;
          else begin cur_d = cur_q + 1'b1; state_d = StScan; end
        end
      end
      StFin1: begin
        if (!hold) begin
          active_d[cur_q] = 1'b0;
          emit = 1'b1;
          e_value = (st.ret != '0) ? st.start : st.target;
          state_d = StFin2;
        end
      end
      StFin2: begin
        if (!hold) begin
          emit = 1'b1; e_kind = KindStop;
          if (cur_last) state_d = StFlush;
          else begin cur_d = cur_q + 1'b1; state_d = StScan; end
        end
      end
      StFlush: begin
        if (!pend_valid_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          flush_move = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      active_q     <= '0;
      tick_q       <= 8'd10;
      minc_q       <= 14'd1;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      if (cfg_valid_i && cfg_index_i == RegTickMs) tick_q <= cfg_data_i[TickW-1:0];
      if (cfg_valid_i && cfg_index_i == RegMinChange) minc_q <= cfg_data_i;
      if (emit) pend_valid_q <= 1'b1;
      else if (flush_move) pend_valid_q <= 1'b0;
      if ((emit && pend_valid_q) || flush_move) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; t_q <= t_d; p_q <= p_d; cv_q <= cv_d; e_q <= e_d; c_q <= c_d;
    prod_q <= prod_d; from_q <= from_d; to_q <= to_d;
    rem_q <= rem_d; den_q <= den_d; quo_q <= quo_d; cnt_q <= cnt_d;
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q         <= s_axis_tuser;
      in_slot_q       <= s_axis_tdata[3:0];
      in_set_q.start  <= s_axis_tdata[17:4];
      in_set_q.target <= s_axis_tdata[31:18];
      in_set_q.delay  <= s_axis_tdata[47:32];
      in_set_q.attack <= s_axis_tdata[63:48];
      in_set_q.ret    <= s_axis_tdata[79:64];
      in_set_q.curve  <= s_axis_tdata[91:80];
    end
    if (el_we) el_q[el_wa] <= el_wd;
    if (set_we) set_q[in_idx] <= in_set_q;
    if (emit) begin
      if (pend_valid_q) begin
        out_q      <= pend_q;
        out_last_q <= 1'b0;
      end
      pend_q <= '{kind: e_kind, slot: e_slot, value: e_value, mask: mask_w};
    end else if (flush_move) begin
      out_q      <= pend_q;
      out_last_q <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {6'b0, out_q.mask, out_q.value, out_q.slot};

  // A new result never overwrites a pending one that cannot move on
  assert property (@(posedge clk_i) disable iff (!rst_ni) emit |-> !hold)
    else $error("result emitted while the output was blocked");

  // Every result of a request has left the pending register before the next request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni) s_axis_tready |-> !pend_valid_q)
    else $error("pending result left over at request acceptance");

  // A flush with nothing pending returns straight to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFlush && !pend_valid_q) |=> state_q == StIdle)
    else $error("flush did not complete");

  // A progress division that reaches its last step hands over to curve setup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivP && cnt_q == 4'd15) |=> state_q == StCset)
    else $error("progress division did not hand over to curve setup");

endmodule

>>> dv/multichannel_curved_ramp_envelope_unit_tb.sv
// Self-checking testbench for the multichannel curved ramp envelope unit.
// Holds a predictor of the slot envelopes and a checker of the result stream.
// Depends on mcre_pkg and multichannel_curved_ramp_envelope_unit.
`timescale 1ns / 1ps

module multichannel_curved_ramp_envelope_unit_tb;
  import mcre_pkg::*;

  // One input request and one predicted result
  typedef struct {
    logic [1:0]  op;
    logic [3:0]  slot;
    logic [13:0] sv;
    logic [13:0] tv;
    logic [15:0] delay;
    logic [15:0] attack;
    logic [15:0] ret;
    logic [11:0] curve;
    bit          drain_first;
  } env_req_t;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [13:0] value;
    logic [15:0] mask;
    logic        last;
  } env_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [13:0] cfg_data_i;

  multichannel_curved_ramp_envelope_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predictor state: configuration and per-slot envelopes
  int unsigned tick_step;
  int unsigned min_delta;
  bit          env_active [16];
  int unsigned env_elapsed [16];
  slot_set_t   env_set [16];

  env_req_t    pending_reqs[$];
  env_res_t    expected_results[$];
  int unsigned reqs_queued, reqs_accepted, results_seen, errors;

  function automatic logic [15:0] active_bits();
    logic [15:0] m;
    m = '0;
    for (int s = 0; s < 16; s++) m[s] = env_active[s];
    return m;
  endfunction

  function automatic void push_result(logic [1:0] kind, int s, logic [13:0] value);
    env_res_t r;
    r.kind  = kind;
    r.slot  = s[3:0];
    r.value = value;
    r.mask  = active_bits();
    r.last  = 1'b0;
    expected_results.push_back(r);
  endfunction

  // Progress raised to the curve exponent via Mitchell log2 and exp2
  function automatic longint shape_progress(longint p, longint cv);
    longint e, n, m, i, f;
    int k;
    if (cv == 1024) return p;
    if (p == 0) return 0;
    if (cv < 1024) e = (1024 + 3 * (1024 - cv)) << 6;
    else e = (longint'(1) << 26) / (3 * cv - 2048);
    k = 15;
    while (k > 0 && ((p >> k) & 1) == 0) k--;
    n = (16 - k) * 65536 - (((p - (longint'(1) << k)) << 16) >> k);
    m = (n * e) >> 16;
    i = m >> 16;
    f = m & 65535;
    if (f == 0) return (i > 17) ? 0 : (longint'(65536) >> i);
    if (i >= 18) return 0;
    return (131072 - f) >> (i + 1);
  endfunction

  function automatic logic [13:0] mix_value(longint from, longint to, longint c);
    longint v;
    v = from + ((to - from) * c) / 65536;
    if (v < 0) v = 0;
    if (v > 16383) v = 16383;
    return v[13:0];
  endfunction

  // Advance one active slot by a tick
  function automatic void step_slot(int s);
    longint t, p;
    slot_set_t st;
    st = env_set[s];
    t = env_elapsed[s] + tick_step;
    if (t > ElapsedMax) t = ElapsedMax;
    env_elapsed[s] = 32'(t);
    if (t < st.delay) return;
    t -= st.delay;
    if (t < st.attack) begin
      p = (t << 16) / st.attack;
      push_result(KindValue, s,
                  mix_value(st.start, st.target, shape_progress(p, longint'(st.curve))));
      return;
    end
    t -= st.attack;
    if (st.ret > 0 && t < st.ret) begin
      p = (t << 16) / st.ret;
      push_result(KindValue, s,
                  mix_value(st.target, st.start, shape_progress(p, 2048 - longint'(st.curve))));
      return;
    end
    env_active[s] = 1'b0;
    push_result(KindValue, s, (st.ret > 0) ? st.start : st.target);
    push_result(KindStop, s, '0);
  endfunction

  // Work out the results caused by one accepted request
  function automatic void predict_envelopes(env_req_t q);
    int first, diff;
    first = expected_results.size();
    case (q.op)
      OpStart: begin
        diff = (q.sv > q.tv) ? q.sv - q.tv : q.tv - q.sv;
        if (!env_active[q.slot] && diff >= min_delta) begin
          if (q.attack == 0) push_result(KindValue, q.slot, q.tv);
          else begin
            env_set[q.slot] = '{start: q.sv, target: q.tv, delay: q.delay,
                                attack: q.attack, ret: q.ret, curve: q.curve};
            env_active[q.slot]  = 1'b1;
            env_elapsed[q.slot] = 0;
            push_result(KindStart, q.slot, '0);
          end
        end
      end
      OpStop: begin
        if (env_active[q.slot]) begin
          env_active[q.slot] = 1'b0;
          push_result(KindStop, q.slot, '0);
        end
      end
      OpStopAll: begin
        for (int s = 0; s < 16; s++)
          if (env_active[s]) begin
            env_active[s] = 1'b0;
            push_result(KindStop, s, '0);
          end
      end
      default: begin
        for (int s = 0; s < 16; s++)
          if (env_active[s]) step_slot(s);
      end
    endcase
    if (expected_results.size() > first)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  // Clock generation
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Request driver with random gaps and an optional hold until drained
  int unsigned send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    env_req_t q;
    logic     nxt_valid;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      send_gap      <= 0;
    end else begin
      nxt_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        q.op = s_axis_tuser;
        {q.curve, q.ret, q.attack, q.delay, q.tv, q.sv, q.slot} = s_axis_tdata[91:0];
        predict_envelopes(q);
        reqs_accepted++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        else if (pending_reqs.size() > 0 &&
                 !(pending_reqs[0].drain_first && expected_results.size() > 0)) begin
          q = pending_reqs.pop_front();
          nxt_valid = 1'b1;
          s_axis_tuser <= q.op;
          s_axis_tdata <= {4'b0, q.curve, q.ret, q.attack, q.delay, q.tv, q.sv, q.slot};
          send_gap <= $urandom_range(0, 5);
        end
      end
      s_axis_tvalid <= nxt_valid;
    end
  end

  // Result monitor with random back-pressure
  int unsigned recv_wait;
  always @(posedge clk_i or negedge rst_ni) begin
    env_res_t e;
    int unsigned w;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_wait     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result kind %0d slot %0d value %0d mask %h",
                   $time, m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[17:4],
                   m_axis_tdata[33:18]);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (m_axis_tuser !== e.kind || m_axis_tdata[3:0] !== e.slot ||
              m_axis_tdata[17:4] !== e.value || m_axis_tdata[33:18] !== e.mask ||
              m_axis_tlast !== e.last) begin
            $display("%0t: mismatch expected kind %0d slot %0d value %0d mask %h last %0d",
                     $time, e.kind, e.slot, e.value, e.mask, e.last);
            $display("%0t:          actual   kind %0d slot %0d value %0d mask %h last %0d",
                     $time, m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[17:4],
                     m_axis_tdata[33:18], m_axis_tlast);
            errors++;
          end
        end
        w = $urandom_range(0, 5);
        recv_wait     <= w;
        m_axis_tready <= (w == 0);
      end else if (recv_wait > 0) begin
        recv_wait     <= recv_wait - 1;
        m_axis_tready <= (recv_wait == 1);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic void queue_req(logic [1:0] op, int slot, int sv, int tv, int delay,
                                    int attack, int ret, int curve, bit drain = 0);
    env_req_t q;
    q = '{op, slot[3:0], sv[13:0], tv[13:0], delay[15:0], attack[15:0], ret[15:0],
          curve[11:0], drain};
    pending_reqs.push_back(q);
    reqs_queued++;
  endfunction

  // Random request, mostly well-formed short envelopes and ticks
  function automatic void queue_random_req();
    int pick, delay, attack, ret, curve;
    pick = $urandom_range(0, 99);
    delay  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 150);
    attack = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 400);
    ret    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) :
             ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
    curve  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 2048);
    if (pick < 35)
      queue_req(OpStart, $urandom_range(0, 15), $urandom_range(0, 16383),
                $urandom_range(0, 16383), delay, attack, ret, curve);
    else if (pick < 45)
      queue_req(OpStop, $urandom_range(0, 15), $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
    else if (pick < 49)
      queue_req(OpStopAll, $urandom_range(0, 15), $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
    else
      queue_req(OpTick, $urandom_range(0, 15), $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
  endfunction

  // Waits until all requests are in, all results are out and the block is quiet
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_reqs.size() > 0 || reqs_accepted != reqs_queued ||
           expected_results.size() > 0);
    repeat (1000) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [13:0] value);
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == RegTickMs) tick_step = value[7:0];
    else min_delta = value;
  endtask

  // Stimulus sequence
  initial begin
    logic [13:0] tick_set [5] = '{14'd1, 14'd255, 14'd37, 14'd0, 14'd10};
    logic [13:0] delta_set [5] = '{14'd0, 14'd16383, 14'd200, 14'd1, 14'd1};
    tick_step = 10;
    min_delta = 1;
    for (int s = 0; s < 16; s++) env_active[s] = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: curve shapes, full-scale values, zero attack and ignored requests
    queue_req(OpStart, 0, 0, 16383, 0, 30, 30, 1024);
    queue_req(OpStart, 1, 16383, 0, 10, 40, 0, 0);
    queue_req(OpStart, 2, 100, 9000, 0, 50, 60, 2048);
    queue_req(OpStart, 15, 8000, 8000, 0, 50, 0, 1024);
    queue_req(OpStart, 3, 5, 16000, 0, 0, 0, 1024);
    queue_req(OpStart, 0, 1, 2, 0, 10, 0, 1024);
    queue_req(OpStart, 4, 0, 16383, 0, 65535, 65535, 4095);
    queue_req(OpStop, 9, 0, 0, 0, 0, 0, 0);
    for (int n = 0; n < 9; n++) queue_req(OpTick, n, 0, 0, 0, 0, 0, 0);
    queue_req(OpStop, 4, 0, 0, 0, 0, 0, 0);
    queue_req(OpStart, 5, 0, 16383, 65535, 65535, 0, 3000);
    queue_req(OpStart, 6, 16383, 0, 0, 20, 20, 100);
    queue_req(OpTick, 0, 0, 0, 0, 0, 0, 0);
    queue_req(OpStopAll, 0, 0, 0, 0, 0, 0, 0);
    queue_req(OpStopAll, 0, 0, 0, 0, 0, 0, 0, 1);
    wait_drained();

    // Random phases, each under its own configuration
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(RegTickMs, tick_set[ph]);
      write_reg(RegMinChange, delta_set[ph]);
      for (int n = 0; n < 82; n++) begin
        if (n == 40) queue_req(OpTick, 0, 0, 0, 0, 0, 0, 0, 1);
        else queue_random_req();
      end
      wait_drained();
    end

    $display("Covered %0d requests and %0d results over five register settings.",
             reqs_accepted, results_seen);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Timeout
  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
